/* hw/rtl/tdcp_pkg.sv */
// Shared types and constants of the texture dictionary chunk parser.
// Beat and record payload structs, configuration bundle, record kinds and
// error codes. Depends on nothing.
package tdcp_pkg;

  // One input beat: a file byte with its side information.
  typedef struct packed {
    logic [7:0]  file_byte;
    logic [31:0] file_size;
    logic        end_of_file;
  } beat_t;

  // One output record.
  typedef struct packed {
    logic [2:0]  record_kind;
    logic [7:0]  texture_number;
    logic [3:0]  mip_number;
    logic [31:0] mip_width;
    logic [31:0] mip_height;
    logic [31:0] bit_depth;
    logic [31:0] row_stride;
    logic [31:0] pixel_offset;
    logic [10:0] palette_size;
    logic [31:0] record_value;
    logic [4:0]  error_code;
    logic        last_record;
  } rec_t;

  // A queued beat as seen by the parser.
  typedef struct packed {
    logic  valid;
    beat_t beat;
  } q_beat_t;

  // Records produced by the parser in one cycle, oldest in rec0.
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } rec_pair_t;

  // Configuration registers.
  typedef struct packed {
    logic [31:0] root_chunk_id;
    logic [31:0] image_chunk_id;
    logic [31:0] texture_chunk_id;
    logic [31:0] struct_chunk_id;
    logic [31:0] string_chunk_id;
    logic [31:0] format_version;
  } cfg_t;

  localparam logic [2:0] CFG_ROOT_ID    = 3'd0;
  localparam logic [2:0] CFG_IMAGE_ID   = 3'd1;
  localparam logic [2:0] CFG_TEXTURE_ID = 3'd2;
  localparam logic [2:0] CFG_STRUCT_ID  = 3'd3;
  localparam logic [2:0] CFG_STRING_ID  = 3'd4;
  localparam logic [2:0] CFG_VERSION    = 3'd5;

  localparam logic [31:0] RST_ROOT_ID    = 32'd35;
  localparam logic [31:0] RST_IMAGE_ID   = 32'd24;
  localparam logic [31:0] RST_TEXTURE_ID = 32'd6;
  localparam logic [31:0] RST_STRUCT_ID  = 32'd1;
  localparam logic [31:0] RST_STRING_ID  = 32'd2;
  localparam logic [31:0] RST_VERSION    = 32'h1803_FFFF;

  typedef enum logic [2:0] {
    KIND_MIP    = 3'd0,
    KIND_FILTER = 3'd1,
    KIND_NAME   = 3'd2,
    KIND_MASK   = 3'd3,
    KIND_DONE   = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_e;

  localparam logic [4:0] ERR_FILE_SMALL     = 5'd0;
  localparam logic [4:0] ERR_ROOT_ID        = 5'd1;
  localparam logic [4:0] ERR_ROOT_VERSION   = 5'd2;
  localparam logic [4:0] ERR_ROOT_SIZE      = 5'd3;
  localparam logic [4:0] ERR_TEX_ZERO       = 5'd4;
  localparam logic [4:0] ERR_TEX_MANY       = 5'd5;
  localparam logic [4:0] ERR_DEVICE_ZERO    = 5'd6;
  localparam logic [4:0] ERR_NMIPS_ROOM     = 5'd7;
  localparam logic [4:0] ERR_NMIPS_RANGE    = 5'd8;
  localparam logic [4:0] ERR_IMG_ROOM       = 5'd9;
  localparam logic [4:0] ERR_IMG_ID         = 5'd10;
  localparam logic [4:0] ERR_IMG_VERSION    = 5'd11;
  localparam logic [4:0] ERR_IMG_SIZE       = 5'd12;
  localparam logic [4:0] ERR_IMG_SMALL      = 5'd13;
  localparam logic [4:0] ERR_IMG_STRUCT     = 5'd14;
  localparam logic [4:0] ERR_IMG_STRUCT_END = 5'd15;
  localparam logic [4:0] ERR_PIXELS         = 5'd16;
  localparam logic [4:0] ERR_TEX_ROOM       = 5'd17;
  localparam logic [4:0] ERR_TEX_ID         = 5'd18;
  localparam logic [4:0] ERR_TEX_VERSION    = 5'd19;
  localparam logic [4:0] ERR_TEX_SIZE       = 5'd20;
  localparam logic [4:0] ERR_TEX_SMALL      = 5'd21;
  localparam logic [4:0] ERR_TEX_STRUCT     = 5'd22;
  localparam logic [4:0] ERR_FILTER_END     = 5'd23;
  localparam logic [4:0] ERR_NAME_ROOM      = 5'd24;
  localparam logic [4:0] ERR_NAME_ID        = 5'd25;
  localparam logic [4:0] ERR_NAME_SIZE      = 5'd26;

  localparam logic [32:0] HDR_LEN  = 33'd12;
  localparam logic [31:0] MIN_FILE = 32'd16;

endpackage

/* hw/rtl/tdcp_front.sv */
// Input side of the chunk parser: a two-entry beat queue.
// Decouples the byte source from the parser. Uses tdcp_pkg.
module tdcp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tdcp_pkg::beat_t in_data_i,
  input  logic            pop_i,
  output tdcp_pkg::q_beat_t head_o
);

  tdcp_pkg::beat_t mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.beat  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_data_i;
    end
  end

endmodule

/* hw/rtl/tdcp_parser.sv */
// Chunk walker of the parser: byte assembly, header checks, record building.
// Takes queued beats and emits up to two records per cycle. Uses tdcp_pkg.
module tdcp_parser #(
  parameter int MAX_TEXTURES = 256,
  parameter int MAX_MIPS     = 16,
  parameter int NAME_CHARS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdcp_pkg::cfg_t      cfg_i,
  input  tdcp_pkg::q_beat_t   head_i,
  output logic                pop_o,
  input  logic                room_i,
  output tdcp_pkg::rec_pair_t recs_o
);

  localparam int TW = $clog2(MAX_TEXTURES + 1);
  localparam int MW = $clog2(MAX_MIPS + 1);
  localparam int CW = $clog2(NAME_CHARS);

  typedef enum logic [4:0] {
    PH_ROOT, PH_COUNT, PH_NMIPS, PH_IMG_HDR, PH_IMG_SHDR, PH_MIP, PH_PIX_SKIP,
    PH_TEX_HDR, PH_TEX_SHDR, PH_FILTER, PH_NAME_HDR, PH_NAME, PH_MASK_HDR,
    PH_MASK, PH_TAIL_SKIP, PH_WAIT, PH_MIP_CHECK
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE, ACT_AFTER_MIP, ACT_BEGIN_MASK, ACT_TAIL_SKIP, ACT_END_TEX,
    ACT_BEGIN_TEX, ACT_BEGIN_IMAGE, ACT_BEGIN_TEX_HDR
  } act_e;

  phase_e       phase_q, phase_d;
  logic [32:0]  pos_q, pos_d;
  logic [31:0]  shift_q, shift_d;
  logic [4:0]   seg_q, seg_d;
  logic [32:0]  root_end_q, root_end_d;
  logic [32:0]  image_end_q, image_end_d;
  logic [32:0]  tex_end_q, tex_end_d;
  logic [32:0]  skip_q, skip_d;
  logic [TW-1:0] tex_total_q, tex_total_d;
  logic [TW-1:0] tex_cnt_q, tex_cnt_d;
  logic [MW-1:0] mip_total_q, mip_total_d;
  logic [MW-1:0] mip_cnt_q, mip_cnt_d;
  logic [31:0]  fld_q [4];
  logic [31:0]  fld_d [4];
  logic [CW-1:0] char_q, char_d;
  logic [15:0]  dev_q, dev_d;
  logic [63:0]  prod_q, prod_d;
  logic         eofh_q, eofh_d;

  tdcp_pkg::beat_t b;
  logic [31:0]  shift_n;
  logic [4:0]   seg_n;
  logic [32:0]  pos_n;
  logic [4:0]   len;
  logic [31:0]  w0, w1, w2;
  logic [33:0]  pos_w1;
  logic [10:0]  pal;
  logic [64:0]  total;
  act_e         act;
  logic         fin_v, fin_err, data_v, eof_eff, rearm;
  logic [4:0]   fin_code;
  tdcp_pkg::rec_t data_rec, fin_rec;

  function automatic logic [4:0] seg_len(phase_e ph);
    unique case (ph)
      PH_COUNT, PH_NMIPS, PH_FILTER: seg_len = 5'd4;
      PH_MIP: seg_len = 5'd16;
      PH_ROOT, PH_IMG_HDR, PH_IMG_SHDR, PH_TEX_HDR, PH_TEX_SHDR,
      PH_NAME_HDR, PH_MASK_HDR: seg_len = 5'd12;
      default: seg_len = 5'd0;
    endcase
  endfunction

  assign b       = head_i.beat;
  assign shift_n = {b.file_byte, shift_q[31:8]};
  assign seg_n   = seg_q + 5'd1;
  assign pos_n   = pos_q + 33'd1;
  assign len     = seg_len(phase_q);
  assign w0      = fld_d[0];
  assign w1      = fld_d[1];
  assign w2      = fld_d[2];
  assign pos_w1  = {1'b0, pos_n} + {2'b00, w1};
  assign pal     = (fld_q[2] < 32'd9) ? (11'd4 << fld_q[2][3:0]) : 11'd0;
  assign total   = {1'b0, prod_q} + {54'd0, pal};

  assign pop_o = head_i.valid && room_i && (phase_q != PH_MIP_CHECK);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    shift_d     = shift_q;
    seg_d       = seg_q;
    root_end_d  = root_end_q;
    image_end_d = image_end_q;
    tex_end_d   = tex_end_q;
    skip_d      = skip_q;
    tex_total_d = tex_total_q;
    tex_cnt_d   = tex_cnt_q;
    mip_total_d = mip_total_q;
    mip_cnt_d   = mip_cnt_q;
    fld_d       = fld_q;
    char_d      = char_q;
    dev_d       = dev_q;
    prod_d      = prod_q;
    eofh_d      = eofh_q;
    act         = ACT_NONE;
    fin_v       = 1'b0;
    fin_err     = 1'b0;
    fin_code    = tdcp_pkg::ERR_FILE_SMALL;
    data_v      = 1'b0;
    data_rec    = '0;
    eof_eff     = 1'b0;
    rearm       = 1'b0;

    if (phase_q == PH_MIP_CHECK) begin
      if (room_i) begin
        eof_eff = eofh_q;
        if (total > {32'd0, image_end_q - pos_q}) begin
          fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_PIXELS;
        end else begin
          data_v = 1'b1;
          data_rec.record_kind    = tdcp_pkg::KIND_MIP;
          data_rec.texture_number = 8'(32'(tex_cnt_q));
          data_rec.mip_number     = 4'(32'(mip_cnt_q));
          data_rec.mip_width      = fld_q[0];
          data_rec.mip_height     = fld_q[1];
          data_rec.bit_depth      = fld_q[2];
          data_rec.row_stride     = fld_q[3];
          data_rec.pixel_offset   = pos_q[31:0];
          data_rec.palette_size   = pal;
          skip_d = image_end_q;
          if (pos_q >= image_end_q) begin
            act = ACT_AFTER_MIP;
          end else begin
            phase_d = PH_PIX_SKIP;
            seg_d   = 5'd0;
          end
        end
      end
    end else if (pop_o) begin
      eof_eff = b.end_of_file;
      if (phase_q == PH_WAIT) begin
        // Trailing bytes after the end record are dropped.
      end else if (phase_q == PH_ROOT && pos_q == 33'd0 && b.file_size < tdcp_pkg::MIN_FILE)
      begin
        fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_FILE_SMALL;
      end else begin
        shift_d = shift_n;
        seg_d   = seg_n;
        pos_d   = pos_n;
        if (len != 5'd0) begin
          if (seg_n[1:0] == 2'd0 && seg_n <= 5'd16) begin
            fld_d[2'(seg_n[3:2] - 2'd1)] = shift_n;
          end
          if (seg_n >= len) begin
            seg_d = 5'd0;
            unique case (phase_q)
              PH_ROOT: begin
                if (w0 != cfg_i.root_chunk_id) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_ROOT_ID;
                end else if (w2 != cfg_i.format_version) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_ROOT_VERSION;
                end else if (tdcp_pkg::HDR_LEN + {1'b0, w1} > {1'b0, b.file_size}) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_ROOT_SIZE;
                end else begin
                  root_end_d = tdcp_pkg::HDR_LEN + {1'b0, w1};
                  phase_d    = PH_COUNT;
                end
              end
              PH_COUNT: begin
                dev_d = w0[31:16];
                if (w0[15:0] == 16'd0) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_ZERO;
                end else if (32'(w0[15:0]) > 32'(MAX_TEXTURES)) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_MANY;
                end else if (w0[31:16] == 16'd0) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_DEVICE_ZERO;
                end else begin
                  tex_total_d = TW'(w0[15:0]);
                  tex_cnt_d   = '0;
                  act         = ACT_BEGIN_TEX;
                end
              end
              PH_NMIPS: begin
                if (w0 == 32'd0 || w0 > 32'(MAX_MIPS)) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_NMIPS_RANGE;
                end else begin
                  mip_total_d = MW'(w0);
                  mip_cnt_d   = '0;
                  act         = ACT_BEGIN_IMAGE;
                end
              end
              PH_IMG_HDR: begin
                if (w0 != cfg_i.image_chunk_id) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_IMG_ID;
                end else if (w2 != cfg_i.format_version) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_IMG_VERSION;
                end else if (pos_w1 > {1'b0, root_end_q}) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_IMG_SIZE;
                end else begin
                  image_end_d = pos_w1[32:0];
                  if (w1 < 32'd12) begin
                    fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_IMG_SMALL;
                  end else begin
                    phase_d = PH_IMG_SHDR;
                  end
                end
              end
              PH_IMG_SHDR: begin
                if (w0 != cfg_i.struct_chunk_id || w1 != 32'd16) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_IMG_STRUCT;
                end else if ({1'b0, pos_n} + 34'd16 > {1'b0, image_end_q}) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_IMG_STRUCT_END;
                end else begin
                  phase_d = PH_MIP;
                end
              end
              PH_MIP: begin
                // Stride times height is registered; the check follows in PH_MIP_CHECK once the output queue has room.
                prod_d  = shift_n * fld_q[1];
                eofh_d  = b.end_of_file;
                eof_eff = 1'b0;
                phase_d = PH_MIP_CHECK;
              end
              PH_TEX_HDR: begin
                if (w0 != cfg_i.texture_chunk_id) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_ID;
                end else if (w2 != cfg_i.format_version) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_VERSION;
                end else if (pos_w1 > {1'b0, root_end_q}) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_SIZE;
                end else begin
                  tex_end_d = pos_w1[32:0];
                  if (w1 < 32'd12) begin
                    fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_SMALL;
                  end else begin
                    phase_d = PH_TEX_SHDR;
                  end
                end
              end
              PH_TEX_SHDR: begin
                if (w0 != cfg_i.struct_chunk_id || w1 != 32'd4) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_STRUCT;
                end else if ({1'b0, pos_n} + 34'd4 > {1'b0, tex_end_q}) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_FILTER_END;
                end else begin
                  phase_d = PH_FILTER;
                end
              end
              PH_FILTER: begin
                data_v = 1'b1;
                data_rec.record_kind    = tdcp_pkg::KIND_FILTER;
                data_rec.texture_number = 8'(32'(tex_cnt_q));
                data_rec.record_value   = w0;
                if ({1'b0, pos_n} + 34'd12 > {1'b0, tex_end_q}) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_NAME_ROOM;
                end else begin
                  phase_d = PH_NAME_HDR;
                end
              end
              PH_NAME_HDR: begin
                if (w0 != cfg_i.string_chunk_id) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_NAME_ID;
                end else if (pos_w1 > {1'b0, tex_end_q}) begin
                  fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_NAME_SIZE;
                end else begin
                  char_d = '0;
                  skip_d = pos_w1[32:0];
                  if (w1 == 32'd0) begin
                    act = ACT_BEGIN_MASK;
                  end else begin
                    phase_d = PH_NAME;
                  end
                end
              end
              PH_MASK_HDR: begin
                // A missing or bad mask string is not an error.
                if (w0 == cfg_i.string_chunk_id && pos_w1 <= {1'b0, tex_end_q}) begin
                  char_d = '0;
                  skip_d = pos_w1[32:0];
                  if (w1 == 32'd0) begin
                    act = ACT_TAIL_SKIP;
                  end else begin
                    phase_d = PH_MASK;
                  end
                end else begin
                  act = ACT_TAIL_SKIP;
                end
              end
              default: begin
              end
            endcase
          end
        end else if (phase_q == PH_NAME || phase_q == PH_MASK) begin
          if (char_q < CW'(NAME_CHARS - 1)) begin
            if (b.file_byte == 8'd0) begin
              char_d = CW'(NAME_CHARS - 1);
            end else begin
              data_v = 1'b1;
              data_rec.record_kind    = (phase_q == PH_NAME) ? tdcp_pkg::KIND_NAME
                                                             : tdcp_pkg::KIND_MASK;
              data_rec.texture_number = 8'(32'(tex_cnt_q));
              data_rec.record_value   = {24'd0, b.file_byte};
              char_d = char_q + CW'(1);
            end
          end
          if (pos_n >= skip_q) begin
            act = (phase_q == PH_NAME) ? ACT_BEGIN_MASK : ACT_TAIL_SKIP;
          end
        end else if (phase_q == PH_PIX_SKIP) begin
          if (pos_n >= skip_q) begin
            act = ACT_AFTER_MIP;
          end
        end else if (phase_q == PH_TAIL_SKIP) begin
          if (pos_n >= skip_q) begin
            act = ACT_END_TEX;
          end
        end
      end
    end

    // Follow-on steps; each may hand over to a later one.
    if (act == ACT_AFTER_MIP) begin
      mip_cnt_d = mip_cnt_q + MW'(1);
      act = (mip_cnt_d >= mip_total_q) ? ACT_BEGIN_TEX_HDR : ACT_BEGIN_IMAGE;
    end
    if (act == ACT_BEGIN_MASK) begin
      if ({1'b0, pos_d} + 34'd12 <= {1'b0, tex_end_q}) begin
        phase_d = PH_MASK_HDR;
        seg_d   = 5'd0;
      end else begin
        act = ACT_TAIL_SKIP;
      end
    end
    if (act == ACT_TAIL_SKIP) begin
      skip_d = tex_end_q;
      if (pos_d >= tex_end_q) begin
        act = ACT_END_TEX;
      end else begin
        phase_d = PH_TAIL_SKIP;
        seg_d   = 5'd0;
      end
    end
    if (act == ACT_END_TEX) begin
      tex_cnt_d = tex_cnt_q + TW'(1);
      act = ACT_BEGIN_TEX;
    end
    if (act == ACT_BEGIN_TEX) begin
      if (tex_cnt_d >= tex_total_d) begin
        fin_v = 1'b1;
      end else if ({1'b0, pos_d} + 34'd4 > {1'b0, root_end_d}) begin
        fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_NMIPS_ROOM;
      end else begin
        phase_d = PH_NMIPS;
        seg_d   = 5'd0;
      end
    end
    if (act == ACT_BEGIN_IMAGE) begin
      if ({1'b0, pos_d} + 34'd12 > {1'b0, root_end_q}) begin
        fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_IMG_ROOM;
      end else begin
        phase_d = PH_IMG_HDR;
        seg_d   = 5'd0;
      end
    end
    if (act == ACT_BEGIN_TEX_HDR) begin
      if ({1'b0, pos_d} + 34'd12 > {1'b0, root_end_q}) begin
        fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_TEX_ROOM;
      end else begin
        phase_d = PH_TEX_HDR;
        seg_d   = 5'd0;
      end
    end

    if (fin_v) begin
      phase_d = PH_WAIT;
    end
    // The marked last byte ends any run still open.
    if (eof_eff) begin
      if (phase_d != PH_WAIT) begin
        fin_v = 1'b1; fin_err = 1'b1; fin_code = tdcp_pkg::ERR_FILE_SMALL;
      end
      rearm = 1'b1;
    end

    fin_rec = '0;
    fin_rec.record_kind  = fin_err ? tdcp_pkg::KIND_ERROR : tdcp_pkg::KIND_DONE;
    fin_rec.record_value = fin_err ? 32'd0 : {16'd0, dev_d};
    fin_rec.error_code   = fin_err ? fin_code : 5'd0;
    fin_rec.last_record  = 1'b1;

    if (rearm) begin
      phase_d     = PH_ROOT;
      pos_d       = '0;
      shift_d     = '0;
      seg_d       = '0;
      root_end_d  = '0;
      image_end_d = '0;
      tex_end_d   = '0;
      skip_d      = '0;
      tex_total_d = '0;
      tex_cnt_d   = '0;
      mip_total_d = '0;
      mip_cnt_d   = '0;
      fld_d       = '{default: '0};
      char_d      = '0;
      dev_d       = '0;
    end
  end

  assign recs_o.count = {1'b0, data_v} + {1'b0, fin_v};
  assign recs_o.rec0  = data_v ? data_rec : fin_rec;
  assign recs_o.rec1  = fin_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ROOT;
      pos_q       <= '0;
      shift_q     <= '0;
      seg_q       <= '0;
      root_end_q  <= '0;
      image_end_q <= '0;
      tex_end_q   <= '0;
      skip_q      <= '0;
      tex_total_q <= '0;
      tex_cnt_q   <= '0;
      mip_total_q <= '0;
      mip_cnt_q   <= '0;
      fld_q       <= '{default: '0};
      char_q      <= '0;
      dev_q       <= '0;
      eofh_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      shift_q     <= shift_d;
      seg_q       <= seg_d;
      root_end_q  <= root_end_d;
      image_end_q <= image_end_d;
      tex_end_q   <= tex_end_d;
      skip_q      <= skip_d;
      tex_total_q <= tex_total_d;
      tex_cnt_q   <= tex_cnt_d;
      mip_total_q <= mip_total_d;
      mip_cnt_q   <= mip_cnt_d;
      fld_q       <= fld_d;
      char_q      <= char_d;
      dev_q       <= dev_d;
      eofh_q      <= eofh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule

/* hw/rtl/tdcp_out_queue.sv */
// Output side of the chunk parser: a four-entry record queue.
// Takes up to two records per cycle, delivers one per beat. Uses tdcp_pkg.
module tdcp_out_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdcp_pkg::rec_pair_t recs_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tdcp_pkg::rec_t      out_data_o
);

  tdcp_pkg::rec_t mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign room_o      = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_data_o  = mem_q[rptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      wptr_q <= wptr_q + recs_i.count;
      rptr_q <= rptr_q + {1'b0, pop};
      cnt_q  <= cnt_q + {1'b0, recs_i.count} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (recs_i.count != 2'd0) begin
      mem_q[wptr_q] <= recs_i.rec0;
    end
    if (recs_i.count == 2'd2) begin
      mem_q[wptr_q + 2'd1] <= recs_i.rec1;
    end
  end

endmodule

/* hw/rtl/texture_dictionary_chunk_parser.sv */
// Top level of the texture dictionary chunk parser.
// Holds the configuration registers and joins front queue, parser and
// output queue. Uses tdcp_pkg, tdcp_front, tdcp_parser, tdcp_out_queue.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------
//   in      | sink      | in_valid_i / in_stall_o | tdcp_pkg::beat_t
//   out     | source    | out_valid_o / out_stall_i | tdcp_pkg::rec_t
//   cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// The parser takes one byte beat per cycle while a beat is queued and the
// output queue has room. After the last byte of each mip descriptor it takes
// no beat while stride times height goes through a registered multiplier before the pixel room check.
// Reset is asynchronous and active low; it returns the walker to the root
// header and loads the default chunk ids and version.
// A two-beat input queue and a four-record output queue let the source and
// the sink stall independently; the parser holds off while fewer than two
// output slots are free.
module texture_dictionary_chunk_parser #(
  parameter int MAX_TEXTURES = 256,
  parameter int MAX_MIPS     = 16,
  parameter int NAME_CHARS   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tdcp_pkg::beat_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tdcp_pkg::rec_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [31:0]     cfg_wdata_i
);

  tdcp_pkg::cfg_t      cfg_q;
  tdcp_pkg::q_beat_t   head;
  tdcp_pkg::rec_pair_t recs;
  logic                pop;
  logic                room;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_chunk_id    <= tdcp_pkg::RST_ROOT_ID;
      cfg_q.image_chunk_id   <= tdcp_pkg::RST_IMAGE_ID;
      cfg_q.texture_chunk_id <= tdcp_pkg::RST_TEXTURE_ID;
      cfg_q.struct_chunk_id  <= tdcp_pkg::RST_STRUCT_ID;
      cfg_q.string_chunk_id  <= tdcp_pkg::RST_STRING_ID;
      cfg_q.format_version   <= tdcp_pkg::RST_VERSION;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdcp_pkg::CFG_ROOT_ID:    cfg_q.root_chunk_id    <= cfg_wdata_i;
        tdcp_pkg::CFG_IMAGE_ID:   cfg_q.image_chunk_id   <= cfg_wdata_i;
        tdcp_pkg::CFG_TEXTURE_ID: cfg_q.texture_chunk_id <= cfg_wdata_i;
        tdcp_pkg::CFG_STRUCT_ID:  cfg_q.struct_chunk_id  <= cfg_wdata_i;
        tdcp_pkg::CFG_STRING_ID:  cfg_q.string_chunk_id  <= cfg_wdata_i;
        tdcp_pkg::CFG_VERSION:    cfg_q.format_version   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front: buffers incoming byte beats.
  tdcp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .pop_i      (pop),
    .head_o     (head)
  );

  // Back: walks the chunk tree and builds records.
  tdcp_parser #(
    .MAX_TEXTURES (MAX_TEXTURES),
    .MAX_MIPS     (MAX_MIPS),
    .NAME_CHARS   (NAME_CHARS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .room_i (room),
    .recs_o (recs)
  );

  // Output queue: absorbs a burst of two records and the sink's stalls.
  tdcp_out_queue u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .recs_i      (recs),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The parser never writes records into a queue without two free slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (recs.count != 2'd0) |-> room)
    else $error("record written without queue room");

  // A beat is only taken from a non-empty input queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("beat popped from empty queue");

  // Only end records carry the last-record flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last_record) |->
      (out_data_o.record_kind == tdcp_pkg::KIND_DONE ||
       out_data_o.record_kind == tdcp_pkg::KIND_ERROR))
    else $error("last record flag on a data record");

endmodule

/* dv/tb_texture_dictionary_chunk_parser.sv */
// Self-checking testbench of the texture dictionary chunk parser.
// Builds texture dictionary files from the current register values and
// predicts every record. Depends on tdcp_pkg and texture_dictionary_chunk_parser.
`timescale 1ns / 1ps

module tb_texture_dictionary_chunk_parser;
  import tdcp_pkg::*;

  // Walker phases of the predictor; they mirror the chunk nesting of the file.
  typedef enum int {
    W_ROOT, W_COUNT, W_NMIPS, W_IMG_HDR, W_IMG_SHDR, W_MIP, W_PIX, W_TEX_HDR,
    W_TEX_SHDR, W_FILTER, W_NAME_HDR, W_NAME, W_MASK_HDR, W_MASK, W_TAIL, W_WAIT
  } walk_e;

  localparam int unsigned TEX_LIMIT  = 256;
  localparam int unsigned MIP_LIMIT  = 16;
  localparam int unsigned CHAR_LIMIT = 31;  // name chars kept per string
  localparam longint unsigned HDR    = 12;
  localparam logic [31:0] EXT_ID     = 32'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  beat_t       in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rec_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_ROOT_ID;
  logic [31:0] cfg_wdata_i = '0;

  texture_dictionary_chunk_parser uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5ms;
    $display("FAIL texture_dictionary_chunk_parser");
    $finish;
  end

  int unsigned idle_pct  = 0;   // chance that the sender inserts a gap
  int unsigned stall_pct = 0;   // chance that the sink stalls
  int          err_cnt   = 0;
  int unsigned bytes_sent = 0;

  // Records the parser is expected to emit, oldest first.
  rec_t pending_recs[$];

  // Shadow of the configuration registers.
  logic [31:0] c_root, c_img, c_tex, c_struct, c_str, c_ver;

  // Predictor state.
  walk_e            walk_ph;
  longint unsigned  at_pos, root_lim, img_lim, tex_lim, skip_to;
  logic [31:0]      asm_word;
  int unsigned      seg_n, tex_total, tex_idx, mip_total, mip_idx, chars;
  logic [31:0]      fld [4];
  logic [15:0]      dev_id;
  int unsigned      recs_this_beat;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void rearm_walker();
    walk_ph = W_ROOT;
    at_pos = 0; asm_word = '0; seg_n = 0;
    root_lim = 0; img_lim = 0; tex_lim = 0; skip_to = 0;
    tex_total = 0; tex_idx = 0; mip_total = 0; mip_idx = 0;
    for (int i = 0; i < 4; i++) fld[i] = '0;
    chars = 0; dev_id = '0;
  endfunction

  function automatic rec_t blank_rec(kind_e k);
    rec_t r;
    r = '0;
    r.record_kind = k;
    r.texture_number = tex_idx[7:0];
    return r;
  endfunction

  // At most two records can come out of one byte.
  function automatic void emit(rec_t r);
    if (recs_this_beat < 2) begin
      pending_recs.push_back(r);
      recs_this_beat++;
    end
  endfunction

  function automatic void end_run(bit is_err, logic [4:0] code);
    rec_t r;
    r = blank_rec(is_err ? KIND_ERROR : KIND_DONE);
    r.texture_number = '0;
    if (is_err) r.error_code = code;
    else r.record_value = {16'h0, dev_id};
    r.last_record = 1'b1;
    emit(r);
    walk_ph = W_WAIT;
  endfunction

  function automatic void enter(walk_e p);
    walk_ph = p;
    seg_n = 0;
  endfunction

  function automatic void start_texture();
    if (tex_idx >= tex_total) end_run(1'b0, ERR_FILE_SMALL);
    else if (at_pos + 4 > root_lim) end_run(1'b1, ERR_NMIPS_ROOM);
    else enter(W_NMIPS);
  endfunction

  function automatic void start_image();
    if (at_pos + HDR > root_lim) end_run(1'b1, ERR_IMG_ROOM);
    else enter(W_IMG_HDR);
  endfunction

  function automatic void next_mip();
    mip_idx++;
    if (mip_idx >= mip_total) begin
      if (at_pos + HDR > root_lim) end_run(1'b1, ERR_TEX_ROOM);
      else enter(W_TEX_HDR);
    end else begin
      start_image();
    end
  endfunction

  function automatic void next_texture();
    tex_idx++;
    start_texture();
  endfunction

  function automatic void skip_tail();
    skip_to = tex_lim;
    if (at_pos >= skip_to) next_texture();
    else enter(W_TAIL);
  endfunction

  function automatic void try_mask();
    if (at_pos + HDR <= tex_lim) enter(W_MASK_HDR);
    else skip_tail();
  endfunction

  function automatic int unsigned header_len(walk_e p);
    case (p)
      W_COUNT, W_NMIPS, W_FILTER: return 4;
      W_MIP: return 16;
      W_ROOT, W_IMG_HDR, W_IMG_SHDR, W_TEX_HDR, W_TEX_SHDR, W_NAME_HDR, W_MASK_HDR:
        return 12;
      default: return 0;
    endcase
  endfunction

  // Called when the fixed-size header or struct of the current phase is complete.
  function automatic void close_segment(longint unsigned fsize);
    longint unsigned w0, w1, h, d, s, pal, need;
    int unsigned     nt;
    rec_t            r;
    w0 = fld[0];
    w1 = fld[1];
    case (walk_ph)
      W_ROOT: begin
        if (fld[0] != c_root) end_run(1'b1, ERR_ROOT_ID);
        else if (fld[2] != c_ver) end_run(1'b1, ERR_ROOT_VERSION);
        else if (HDR + w1 > fsize) end_run(1'b1, ERR_ROOT_SIZE);
        else begin
          root_lim = HDR + w1;
          enter(W_COUNT);
        end
      end
      W_COUNT: begin
        nt = fld[0][15:0];
        dev_id = fld[0][31:16];
        if (nt == 0) end_run(1'b1, ERR_TEX_ZERO);
        else if (nt > TEX_LIMIT) end_run(1'b1, ERR_TEX_MANY);
        else if (dev_id == 0) end_run(1'b1, ERR_DEVICE_ZERO);
        else begin
          tex_total = nt;
          tex_idx = 0;
          start_texture();
        end
      end
      W_NMIPS: begin
        if (w0 == 0 || w0 > MIP_LIMIT) end_run(1'b1, ERR_NMIPS_RANGE);
        else begin
          mip_total = w0;
          mip_idx = 0;
          start_image();
        end
      end
      W_IMG_HDR: begin
        if (fld[0] != c_img) end_run(1'b1, ERR_IMG_ID);
        else if (fld[2] != c_ver) end_run(1'b1, ERR_IMG_VERSION);
        else if (at_pos + w1 > root_lim) end_run(1'b1, ERR_IMG_SIZE);
        else begin
          img_lim = at_pos + w1;
          if (at_pos + HDR > img_lim) end_run(1'b1, ERR_IMG_SMALL);
          else enter(W_IMG_SHDR);
        end
      end
      W_IMG_SHDR: begin
        if (fld[0] != c_struct || fld[1] != 32'd16) end_run(1'b1, ERR_IMG_STRUCT);
        else if (at_pos + 16 > img_lim) end_run(1'b1, ERR_IMG_STRUCT_END);
        else enter(W_MIP);
      end
      W_MIP: begin
        h = fld[1];
        d = fld[2];
        s = fld[3];
        pal = (d < 9) ? (longint'(4) << d) : 0;
        // The product of two 32-bit words always fits in 64 bits, so no wrap.
        need = s * h + pal;
        if (need > img_lim - at_pos) begin
          end_run(1'b1, ERR_PIXELS);
        end else begin
          r = blank_rec(KIND_MIP);
          r.mip_number = mip_idx[3:0];
          r.mip_width = fld[0];
          r.mip_height = fld[1];
          r.bit_depth = fld[2];
          r.row_stride = fld[3];
          r.pixel_offset = at_pos[31:0];
          r.palette_size = pal[10:0];
          emit(r);
          skip_to = img_lim;
          if (at_pos >= skip_to) next_mip();
          else enter(W_PIX);
        end
      end
      W_TEX_HDR: begin
        if (fld[0] != c_tex) end_run(1'b1, ERR_TEX_ID);
        else if (fld[2] != c_ver) end_run(1'b1, ERR_TEX_VERSION);
        else if (at_pos + w1 > root_lim) end_run(1'b1, ERR_TEX_SIZE);
        else begin
          tex_lim = at_pos + w1;
          if (at_pos + HDR > tex_lim) end_run(1'b1, ERR_TEX_SMALL);
          else enter(W_TEX_SHDR);
        end
      end
      W_TEX_SHDR: begin
        if (fld[0] != c_struct || fld[1] != 32'd4) end_run(1'b1, ERR_TEX_STRUCT);
        else if (at_pos + 4 > tex_lim) end_run(1'b1, ERR_FILTER_END);
        else enter(W_FILTER);
      end
      W_FILTER: begin
        r = blank_rec(KIND_FILTER);
        r.record_value = fld[0];
        emit(r);
        if (at_pos + HDR > tex_lim) end_run(1'b1, ERR_NAME_ROOM);
        else enter(W_NAME_HDR);
      end
      W_NAME_HDR: begin
        if (fld[0] != c_str) end_run(1'b1, ERR_NAME_ID);
        else if (at_pos + w1 > tex_lim) end_run(1'b1, ERR_NAME_SIZE);
        else begin
          chars = 0;
          skip_to = at_pos + w1;
          if (w1 == 0) try_mask();
          else enter(W_NAME);
        end
      end
      W_MASK_HDR: begin
        // A missing or malformed mask string is not an error; it is skipped.
        if (fld[0] == c_str && at_pos + w1 <= tex_lim) begin
          chars = 0;
          skip_to = at_pos + w1;
          if (w1 == 0) skip_tail();
          else enter(W_MASK);
        end else begin
          skip_tail();
        end
      end
      default: ;
    endcase
  endfunction

  // Advances the predictor by one accepted beat and queues what it causes.
  function automatic void parse_byte(beat_t bt);
    int unsigned len;
    rec_t        r;
    recs_this_beat = 0;
    if (walk_ph == W_WAIT) begin
      if (bt.end_of_file) rearm_walker();
      return;
    end
    if (walk_ph == W_ROOT && at_pos == 0 && bt.file_size < MIN_FILE) begin
      end_run(1'b1, ERR_FILE_SMALL);
      if (bt.end_of_file) rearm_walker();
      return;
    end
    asm_word = {bt.file_byte, asm_word[31:8]};
    seg_n++;
    at_pos++;
    len = header_len(walk_ph);
    if (len != 0) begin
      if (seg_n % 4 == 0 && seg_n <= 16) fld[((seg_n >> 2) - 1) & 3] = asm_word;
      if (seg_n >= len) close_segment(longint'(bt.file_size));
    end else if (walk_ph == W_NAME || walk_ph == W_MASK) begin
      if (chars < CHAR_LIMIT) begin
        // A zero byte ends the kept part of the string and is not reported.
        if (bt.file_byte == 8'h00) begin
          chars = CHAR_LIMIT;
        end else begin
          r = blank_rec(walk_ph == W_NAME ? KIND_NAME : KIND_MASK);
          r.record_value = {24'h0, bt.file_byte};
          emit(r);
          chars++;
        end
      end
      if (at_pos >= skip_to) begin
        if (walk_ph == W_NAME) try_mask();
        else skip_tail();
      end
    end else if (walk_ph == W_PIX) begin
      if (at_pos >= skip_to) next_mip();
    end else if (walk_ph == W_TAIL) begin
      if (at_pos >= skip_to) next_texture();
    end
    if (bt.end_of_file) begin
      if (walk_ph != W_WAIT) end_run(1'b1, ERR_FILE_SMALL);
      rearm_walker();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Record checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    rec_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_recs.size() == 0) begin
        $error("record_kind: expected no record, got 0x%08h", out_data_o.record_kind);
        err_cnt++;
      end else begin
        e = pending_recs.pop_front();
        check_field("record_kind", e.record_kind, out_data_o.record_kind);
        check_field("texture_number", e.texture_number, out_data_o.texture_number);
        check_field("mip_number", e.mip_number, out_data_o.mip_number);
        check_field("mip_width", e.mip_width, out_data_o.mip_width);
        check_field("mip_height", e.mip_height, out_data_o.mip_height);
        check_field("bit_depth", e.bit_depth, out_data_o.bit_depth);
        check_field("row_stride", e.row_stride, out_data_o.row_stride);
        check_field("pixel_offset", e.pixel_offset, out_data_o.pixel_offset);
        check_field("palette_size", e.palette_size, out_data_o.palette_size);
        check_field("record_value", e.record_value, out_data_o.record_value);
        check_field("error_code", e.error_code, out_data_o.error_code);
        check_field("last_record", e.last_record, out_data_o.last_record);
      end
    end
  end

  // The sink stalls at random with the chance of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // File builder. Chunk ids and versions follow the current registers, so a
  // clean file walks all the way to the done record.
  // ---------------------------------------------------------------------------
  logic [7:0] fq[$];

  // Knobs of the directed cases; a negative value means random.
  int k_mips, k_name_len, k_mask, k_depth;
  bit k_huge, k_name_zero;

  function automatic void reset_knobs();
    k_mips = -1; k_name_len = -1; k_mask = -1; k_depth = -1;
    k_huge = 1'b0; k_name_zero = 1'b0;
  endfunction

  function automatic void put32(logic [31:0] w);
    for (int i = 0; i < 4; i++) fq.push_back(w[8*i +: 8]);
  endfunction

  function automatic void patch32(int idx, logic [31:0] w);
    for (int i = 0; i < 4; i++) fq[idx + i] = w[8*i +: 8];
  endfunction

  function automatic void put_string(int len, bit with_zero);
    put32(c_str);
    put32(len);
    put32(c_ver);
    for (int i = 0; i < len; i++) begin
      if ((with_zero && i == len / 2) || $urandom_range(19) == 0) fq.push_back(8'h00);
      else fq.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  function automatic void build_texture();
    int          nm, start, sz_idx, extra, len;
    logic [31:0] h, d, s, pal;
    nm = (k_mips >= 0) ? k_mips : $urandom_range(1, 3);
    put32(nm);
    for (int m = 0; m < nm && m < MIP_LIMIT + 1; m++) begin
      start = fq.size();
      sz_idx = start + 4;
      put32(c_img); put32(0); put32(c_ver);
      put32(c_struct); put32(16); put32(c_ver);
      h = $urandom_range(1, 4);
      s = $urandom_range(1, 8);
      if (k_depth >= 0) d = k_depth;
      else case ($urandom_range(19))
        0:       d = 8;
        1, 2, 3: d = 4;
        4:       d = $urandom;
        5:       d = $urandom_range(0, 3);
        default: d = $urandom_range(0, 1) ? 16 : 32;
      endcase
      if (k_huge) begin
        h = 32'hFFFF_FFFF;
        s = 32'hFFFF_FFFF;
      end
      put32($urandom); put32(h); put32(d); put32(s);
      if (k_huge) begin
        put32($urandom);
      end else begin
        pal = (d < 9) ? (32'd4 << d) : 32'd0;
        extra = $urandom_range(0, 3);
        for (int i = 0; i < int'(s * h + pal) + extra; i++) fq.push_back(8'($urandom));
      end
      patch32(sz_idx, fq.size() - start - 12);
    end
    start = fq.size();
    sz_idx = start + 4;
    put32(c_tex); put32(0); put32(c_ver);
    put32(c_struct); put32(4); put32(c_ver);
    put32($urandom);
    len = (k_name_len >= 0) ? k_name_len : $urandom_range(0, 12);
    put_string(len, k_name_zero);
    if ((k_mask >= 0) ? (k_mask != 0) : $urandom_range(0, 1)) put_string($urandom_range(0, 6), 1'b0);
    // Extension chunk, skipped by the parser.
    if ($urandom_range(0, 1)) begin
      len = $urandom_range(0, 4);
      put32(EXT_ID); put32(len); put32(c_ver);
      for (int i = 0; i < len; i++) fq.push_back(8'($urandom));
    end
    patch32(sz_idx, fq.size() - start - 12);
  endfunction

  function automatic void build_txd(logic [31:0] count_word, int ntex);
    fq.delete();
    put32(c_root); put32(0); put32(c_ver);
    put32(count_word);
    for (int t = 0; t < ntex; t++) build_texture();
    patch32(4, fq.size() - 12);
  endfunction

  function automatic logic [31:0] count_word(int nt);
    return {16'($urandom_range(1, 16'hFFFF)), 16'(nt)};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_beat(beat_t bt);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= bt;
    parse_byte(bt);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic stream_file(logic [31:0] fsz);
    beat_t bt;
    for (int i = 0; i < fq.size(); i++) begin
      bt.file_byte = fq[i];
      bt.file_size = fsz;
      bt.end_of_file = (i == fq.size() - 1);
      send_beat(bt);
    end
  endtask

  task automatic build_and_send(logic [31:0] cw, int ntex);
    build_txd(cw, ntex);
    stream_file(fq.size());
    reset_knobs();
  endtask

  // Waits until every record is out and the parser has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROOT_ID:    c_root = v;
      CFG_IMAGE_ID:   c_img = v;
      CFG_TEXTURE_ID: c_tex = v;
      CFG_STRUCT_ID:  c_struct = v;
      CFG_STRING_ID:  c_str = v;
      CFG_VERSION:    c_ver = v;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(logic [31:0] r0, r1, r2, r3, r4, r5);
    wait_idle();
    write_reg(CFG_ROOT_ID, r0);
    write_reg(CFG_IMAGE_ID, r1);
    write_reg(CFG_TEXTURE_ID, r2);
    write_reg(CFG_STRUCT_ID, r3);
    write_reg(CFG_STRING_ID, r4);
    write_reg(CFG_VERSION, r5);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One file per special case, on the reset register values.
  task automatic test_directed();
    // File size below the minimum: error on the first byte, rest ignored.
    fq = '{8'h00, 8'hFF, 8'h23};
    stream_file(32'd15);
    // Long name is cut after the kept length; mask present; small palette.
    k_name_len = 40; k_mask = 1; k_depth = 4;
    build_and_send(count_word(1), 1);
    // Zero inside the name stops it; mask absent; largest palette.
    k_name_zero = 1'b1; k_name_len = 10; k_mask = 0; k_depth = 8;
    build_and_send(count_word(2), 2);
    // Stride times height far beyond the image chunk, compared without wrap.
    k_huge = 1'b1;
    build_and_send(count_word(1), 1);
    // Device id zero, texture count zero and above the maximum.
    build_and_send(32'h0000_0001, 1);
    build_and_send({16'h0001, 16'h0000}, 1);
    build_and_send({16'hFFFF, 16'(TEX_LIMIT + 1)}, 1);
    build_and_send(32'hFFFF_FFFF, 1);
    // Maximum, one beyond the maximum and zero mip count.
    k_mips = MIP_LIMIT; k_depth = 32;
    build_and_send(count_word(1), 1);
    k_mips = MIP_LIMIT + 1;
    build_and_send(count_word(1), 1);
    k_mips = 0;
    build_and_send(count_word(1), 1);
    // Bytes after the done record are ignored up to the end of the file.
    build_txd(count_word(1), 1);
    repeat (5) fq.push_back(8'($urandom));
    stream_file(fq.size());
    // End of file before the run has finished.
    build_txd(count_word(1), 1);
    fq = fq[0:fq.size() / 2];
    stream_file(32'hFFFF_FFFF);
    // Largest file size on a clean file.
    build_txd(count_word(3), 3);
    stream_file(32'hFFFF_FFFF);
  endtask

  // Half well-formed files with random content, the rest damaged or noise.
  task automatic test_random_files(int unsigned n_bytes);
    int unsigned stop_at, mode, nt, idx;
    logic [31:0] fsz;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      mode = $urandom_range(99);
      nt = $urandom_range(1, 3);
      build_txd(count_word(nt), nt);
      fsz = fq.size();
      if (mode < 50) begin
        // clean
      end else if (mode < 72) begin
        idx = $urandom_range(0, fq.size() - 1);
        fq[idx] = fq[idx] ^ 8'($urandom_range(1, 255));
      end else if (mode < 82) begin
        fq = fq[0:$urandom_range(0, fq.size() - 2)];
      end else if (mode < 90) begin
        repeat ($urandom_range(1, 6)) fq.push_back(8'($urandom));
        fsz = fq.size();
      end else if (mode < 95) begin
        fsz = $urandom;
      end else begin
        fq.delete();
        repeat ($urandom_range(1, 24)) fq.push_back(8'($urandom));
        fsz = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
      end
      stream_file(fsz);
    end
  endtask

  initial begin
    reset_knobs();
    c_root = RST_ROOT_ID; c_img = RST_IMAGE_ID; c_tex = RST_TEXTURE_ID;
    c_struct = RST_STRUCT_ID; c_str = RST_STRING_ID; c_ver = RST_VERSION;
    rearm_walker();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();

    apply_cfg('0, '0, '0, '0, '0, '0);
    idle_pct = 0; stall_pct = 0;
    test_random_files(140);

    apply_cfg('1, '1, '1, '1, '1, '1);
    idle_pct = 67; stall_pct = 0;
    test_random_files(140);

    apply_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    idle_pct = 0; stall_pct = 67;
    test_random_files(140);

    apply_cfg(RST_ROOT_ID, RST_IMAGE_ID, RST_TEXTURE_ID, RST_STRUCT_ID, RST_STRING_ID,
              RST_VERSION);
    idle_pct = 33; stall_pct = 33;
    test_random_files(140);

    wait_idle();
    if (err_cnt == 0) begin
      $display("PASS texture_dictionary_chunk_parser");
    end else begin
      $display("FAIL texture_dictionary_chunk_parser");
    end
    $finish;
  end

endmodule
